FILE: rtl/dwmc_pkg.sv
// shared types and constants for the dictionary word match counter
package dwmc_pkg;

  localparam int DICT_ENTRIES_DEF = 256;
  localparam int KEY_BYTES_DEF    = 32;
  localparam int RAW_BYTES        = 31;
  localparam int USED_W           = 9;
  localparam int INDEX_W          = 8;
  localparam int COUNT_W          = 31;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_COUNT = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic {
    ST_IDLE,
    ST_SWEEP
  } state_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  entry_index;
    logic [63:0] key_bytes_0_to_7;
    logic [63:0] key_bytes_8_to_15;
    logic [63:0] key_bytes_16_to_23;
    logic [55:0] key_bytes_24_to_30;
  } in_item_t;

  typedef struct packed {
    logic               matched;
    logic [INDEX_W-1:0] match_index;
    logic [COUNT_W-1:0] occurrence_count;
  } result_t;

  // transaction walking down the row of cells
  typedef struct packed {
    logic    valid;
    result_t res;
  } token_t;

  // command held by the controller and broadcast to every cell
  typedef struct packed {
    op_t                op;
    logic [INDEX_W-1:0] entry_index;
    logic [USED_W-1:0]  used;
  } bcast_t;

endpackage

FILE: rtl/dwmc_cell.sv
// one dictionary cell: key, count and one stage of the result token
module dwmc_cell #(
  parameter int KEY_W = 248,
  parameter int IDX_W = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  dwmc_pkg::bcast_t     cmd,
  input  logic [KEY_W-1:0]     word,
  input  logic [IDX_W-1:0]     sweep_idx,
  input  dwmc_pkg::token_t     tok_in,
  output dwmc_pkg::token_t     tok_out
);
  import dwmc_pkg::*;

  localparam int CW = (IDX_W > USED_W) ? IDX_W : USED_W;
  localparam int AW = (IDX_W > INDEX_W) ? IDX_W : INDEX_W;

  logic [KEY_W-1:0]   key;
  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] count_next;
  logic [COUNT_W-1:0] count_inc;
  token_t             tok_next;
  logic               in_use;
  logic               addressed;
  logic               hit;
  logic               load_here;

  always_comb begin
    in_use    = CW'(sweep_idx) < CW'(cmd.used);
    addressed = AW'(sweep_idx) == AW'(cmd.entry_index);
    hit       = tok_in.valid && (cmd.op == OP_COUNT) && in_use && (key == word);
    load_here = tok_in.valid && (cmd.op == OP_LOAD) && addressed;
    count_inc = (count == COUNT_MAX) ? count : count + COUNT_W'(1);

    count_next = count;
    if (hit) begin
      count_next = count_inc;
    end
    if (load_here) begin
      count_next = '0;
    end

    tok_next = tok_in;
    // lowest matching entry is the first one the token meets
    if (hit && !tok_in.res.matched) begin
      tok_next.res.matched          = 1'b1;
      tok_next.res.match_index      = INDEX_W'(sweep_idx);
      tok_next.res.occurrence_count = count_inc;
    end
    if (tok_in.valid && (cmd.op == OP_READ) && addressed) begin
      tok_next.res.occurrence_count = count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load_here) begin
      key <= word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out.valid <= tok_next.valid;
    end
    tok_out.res <= tok_next.res;
  end

endmodule

FILE: rtl/dwmc_ctrl.sv
// controller: input capture, key cleanup, config register, sweep index
module dwmc_ctrl #(
  parameter int KEY_W = 248,
  parameter int IDX_W = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  dwmc_pkg::in_item_t            item,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [dwmc_pkg::USED_W-1:0]   cfg_data,
  input  logic                          done,
  output dwmc_pkg::bcast_t              cmd,
  output logic [KEY_W-1:0]              word,
  output logic [IDX_W-1:0]              sweep_idx,
  output dwmc_pkg::token_t              tok0
);
  import dwmc_pkg::*;

  localparam int KEY_LEN = KEY_W / 8;

  state_t                 state;
  state_t                 state_next;
  logic                   accept;
  logic [RAW_BYTES*8-1:0] raw;
  logic [KEY_W-1:0]       canon;
  logic                   keep;
  logic [USED_W-1:0]      used;
  op_t                    op_in;
  op_t                    cmd_op;
  logic [INDEX_W-1:0]     cmd_index;

  always_comb begin
    raw = {item.key_bytes_24_to_30, item.key_bytes_16_to_23,
           item.key_bytes_8_to_15, item.key_bytes_0_to_7};
    // zero everything from the first zero byte on
    keep  = 1'b1;
    canon = '0;
    for (int b = 0; b < KEY_LEN; b++) begin
      keep = keep && (raw[8*b +: 8] != 8'd0);
      canon[8*b +: 8] = keep ? raw[8*b +: 8] : 8'd0;
    end
  end

  always_comb begin
    state_next = state;
    busy       = (state == ST_SWEEP);
    accept     = start && !busy;
    cfg_ready  = !busy;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        if (done) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else if (cfg_valid && cfg_ready) begin
      used <= cfg_data;
    end
  end

  assign op_in = op_t'(item.operation);

  always_ff @(posedge clk) begin
    if (rst) begin
      tok0.valid <= 1'b0;
    end else begin
      tok0.valid <= accept;
    end
    if (accept) begin
      cmd_op          <= op_in;
      cmd_index       <= item.entry_index;
      word            <= canon;
      sweep_idx       <= '0;
      tok0.res.matched          <= 1'b0;
      tok0.res.occurrence_count <= '0;
      tok0.res.match_index      <= (op_in == OP_LOAD || op_in == OP_READ) ?
                                   item.entry_index : '0;
    end else if (busy) begin
      sweep_idx <= sweep_idx + IDX_W'(1);
    end
  end

  assign cmd = '{op: cmd_op, entry_index: cmd_index, used: used};

endmodule

FILE: rtl/dictionary_word_match_counter_top.sv
// Dictionary word match counter: row of cells, one per dictionary entry.
// Start is taken only while not busy; busy stays high until the result strobe,
// so a new operation waits for the last one. The token steps through one cell
// per cycle. The receiver cannot stall results.
// Reset clears all counts, entries_in_use and control state at once;
// keys are undefined until loaded.
module dictionary_word_match_counter_top #(
  parameter int DICT_ENTRIES = dwmc_pkg::DICT_ENTRIES_DEF,
  parameter int KEY_BYTES    = dwmc_pkg::KEY_BYTES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  dwmc_pkg::in_item_t          item,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [dwmc_pkg::USED_W-1:0] cfg_data,
  output logic                        done,
  output dwmc_pkg::result_t           result
);
  import dwmc_pkg::*;

  localparam int KEY_W = (KEY_BYTES - 1) * 8;
  localparam int IDX_W = (DICT_ENTRIES > 1) ? $clog2(DICT_ENTRIES) : 1;

  bcast_t           cmd;
  logic [KEY_W-1:0] word;
  logic [IDX_W-1:0] sweep_idx;
  token_t           chain [DICT_ENTRIES+1];

  dwmc_ctrl #(
    .KEY_W (KEY_W),
    .IDX_W (IDX_W)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .done      (done),
    .cmd       (cmd),
    .word      (word),
    .sweep_idx (sweep_idx),
    .tok0      (chain[0])
  );

  for (genvar g = 0; g < DICT_ENTRIES; g++) begin : g_cell
    dwmc_cell #(
      .KEY_W (KEY_W),
      .IDX_W (IDX_W)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .cmd       (cmd),
      .word      (word),
      .sweep_idx (sweep_idx),
      .tok_in    (chain[g]),
      .tok_out   (chain[g+1])
    );
  end

  assign done   = chain[DICT_ENTRIES].valid;
  assign result = chain[DICT_ENTRIES].res;

endmodule

FILE: rtl/dwmc_checker.sv
// port-level checks for the dictionary word match counter, bound to the top
module dwmc_port_checks (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              done,
  input dwmc_pkg::result_t result
);

  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("result strobe outside an operation");

  a_take_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  a_one_strobe: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe longer than one cycle");

  a_match_count: assert property (@(posedge clk) disable iff (rst)
    (done && result.matched) |-> (result.occurrence_count != '0))
    else $error("match reported with zero count");

  a_busy_end: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> $past(done))
    else $error("busy dropped without a result");

endmodule

bind dictionary_word_match_counter_top dwmc_port_checks u_chk (.*);
